// ===== src/perspective_inverse_map_top_assert.svh =====
// Assertion macros used by the perspective inverse map RTL.
// Depends on nothing; included by perspective_inverse_map_top to check its own logic.
`ifndef PERSPECTIVE_INVERSE_MAP_TOP_ASSERT_SVH
`define PERSPECTIVE_INVERSE_MAP_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PIM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every edge.
`define PIM_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/pim_pkg.sv =====
// Types and fixed constants of the perspective inverse map.
// Used by every module of the block; depends on nothing.
package pim_pkg;

   localparam int COEF_W   = 32;
   localparam int NUM_COEF = 8;
   localparam int FIELD_W  = 12;
   localparam int CRD_W    = 16;           // widest coordinate the datapath carries
   localparam int MUL_W    = COEF_W + CRD_W + 1;
   localparam int SUM_W    = 50;           // exact Q16.16 sums of three terms
   localparam int MAG_W    = SUM_W;
   localparam int REM_W    = 64;           // room for the divisor shifted by QBITS-1
   localparam int DVS_W    = MAG_W + 1;
   localparam int QBITS    = 14;           // 13 useful bits plus one overflow bit
   localparam int IDX_W    = 3;
   localparam logic signed [SUM_W-1:0] DEN_ONE = SUM_W'(65536);

   typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_array_type;

   localparam coef_array_type COEF_RESET = {
      32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd65536};

   typedef struct packed {
      logic [FIELD_W-1:0] out_x;
      logic [FIELD_W-1:0] out_y;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] src_x;
      logic [FIELD_W-1:0] src_y;
      logic               inside_res;
   } rsp_type;

   // Payload moving down the divider chain.
   typedef struct packed {
      logic [REM_W-1:0] rem_x;
      logic [REM_W-1:0] rem_y;
      logic [DVS_W-1:0] dvs;
      logic [QBITS-1:0] q_x;
      logic [QBITS-1:0] q_y;
      logic             neg_x;
      logic             neg_y;
      logic             den_zero;
   } div_type;

endpackage

// ===== src/pim_front.sv =====
// Front end: products, Q16.16 sums and the division setup for each beat.
// Depends on pim_pkg.
module pim_front
   import pim_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic           clock,
   input  logic           reset,
   input  coef_array_type coef,
   input  logic           in_valid,
   output logic           in_ready,
   input  req_type        in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output div_type        out_data
);

   localparam logic [CRD_W-1:0] CRD_MASK = CRD_W'((64'd1 << COORD_BITS) - 64'd1);

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   logic signed [MUL_W-1:0] p_ff [6];
   logic signed [SUM_W-1:0] nx_ff, ny_ff, dn_ff;
   div_type d3_ff, d3_in;
   logic signed [MUL_W-1:0] p_in [6];
   logic signed [CRD_W:0] xs, ys;
   logic [MAG_W-1:0] mx, my, md;

   // Stall chain: a stage loads when empty or when its successor loads.
   assign en3 = !v3_ff || out_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   // Stage one: six signed products, coordinates masked to COORD_BITS.
   always_comb begin
      xs = {1'b0, CRD_W'(in_data.out_x) & CRD_MASK};
      ys = {1'b0, CRD_W'(in_data.out_y) & CRD_MASK};
      p_in[0] = $signed(coef[0]) * xs;
      p_in[1] = $signed(coef[1]) * ys;
      p_in[2] = $signed(coef[3]) * xs;
      p_in[3] = $signed(coef[4]) * ys;
      p_in[4] = $signed(coef[6]) * xs;
      p_in[5] = $signed(coef[7]) * ys;
   end

   // Stage three: magnitudes, signs and the rounding-biased dividend.
   always_comb begin
      mx = nx_ff[SUM_W-1] ? MAG_W'(-nx_ff) : MAG_W'(nx_ff);
      my = ny_ff[SUM_W-1] ? MAG_W'(-ny_ff) : MAG_W'(ny_ff);
      md = dn_ff[SUM_W-1] ? MAG_W'(-dn_ff) : MAG_W'(dn_ff);
      d3_in.rem_x    = REM_W'({mx, 1'b0}) + REM_W'(md);
      d3_in.rem_y    = REM_W'({my, 1'b0}) + REM_W'(md);
      d3_in.dvs      = {md, 1'b0};
      d3_in.q_x      = '0;
      d3_in.q_y      = '0;
      d3_in.neg_x    = nx_ff[SUM_W-1] ^ dn_ff[SUM_W-1];
      d3_in.neg_y    = ny_ff[SUM_W-1] ^ dn_ff[SUM_W-1];
      d3_in.den_zero = (dn_ff == '0);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Payload registers; stage two adds the constant terms.
   always_ff @(posedge clock) begin
      if (en1) begin
         for (int i = 0; i < 6; i++) p_ff[i] <= p_in[i];
      end
      if (en2) begin
         nx_ff <= SUM_W'(p_ff[0]) + SUM_W'(p_ff[1]) + SUM_W'($signed(coef[2]));
         ny_ff <= SUM_W'(p_ff[2]) + SUM_W'(p_ff[3]) + SUM_W'($signed(coef[5]));
         dn_ff <= SUM_W'(p_ff[4]) + SUM_W'(p_ff[5]) + DEN_ONE;
      end
      if (en3) d3_ff <= d3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = d3_ff;

endmodule

// ===== src/pim_div_cell.sv =====
// One restoring-division cell: decides quotient bit SHIFT for both axes.
// Depends on pim_pkg.
module pim_div_cell
   import pim_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic    v_ff;
   div_type d_ff, d_in;
   logic [REM_W-1:0] dsh;
   logic ge_x, ge_y;

   assign in_ready = !v_ff || out_ready;

   // Compare against the shifted divisor and subtract where it fits.
   always_comb begin
      dsh  = REM_W'(in_data.dvs) << SHIFT;
      ge_x = in_data.rem_x >= dsh;
      ge_y = in_data.rem_y >= dsh;
      d_in = in_data;
      if (ge_x) d_in.rem_x = in_data.rem_x - dsh;
      if (ge_y) d_in.rem_y = in_data.rem_y - dsh;
      d_in.q_x[SHIFT] = ge_x;
      d_in.q_y[SHIFT] = ge_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

// ===== src/pim_back.sv =====
// Output stage: sign and range checks on the quotients, result register.
// Depends on pim_pkg.
module pim_back
   import pim_pkg::*;
#(
   parameter int SRC_WIDTH  = 1920,
   parameter int SRC_HEIGHT = 1080
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   localparam logic [QBITS-1:0] LIM_X = QBITS'(SRC_WIDTH);
   localparam logic [QBITS-1:0] LIM_Y = QBITS'(SRC_HEIGHT);

   logic    v_ff;
   rsp_type r_ff, r_in;
   logic ok_x, ok_y, ok;

   assign in_ready = !v_ff || out_ready;

   // A negative quotient is only allowed when it rounded to zero.
   always_comb begin
      ok_x = !(in_data.neg_x && in_data.q_x != '0) && (in_data.q_x < LIM_X);
      ok_y = !(in_data.neg_y && in_data.q_y != '0) && (in_data.q_y < LIM_Y);
      ok   = !in_data.den_zero && ok_x && ok_y;
      r_in.inside_res = ok;
      r_in.src_x      = ok ? FIELD_W'(in_data.q_x) : '0;
      r_in.src_y      = ok ? FIELD_W'(in_data.q_y) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) r_ff <= r_in;
   end

   assign out_valid = v_ff;
   assign out_data  = r_ff;

endmodule

// ===== src/perspective_inverse_map_top.sv =====
// Maps each output pixel (out_x, out_y) to its nearest source pixel under a
// Q16.16 homography held in eight coefficient registers. One beat is taken per
// clock unless rsp_ready stalls the pipeline; each beat passes the multiply,
// sum and setup registers, fourteen cells of restoring division (one quotient
// bit per cell, both axes side by side) and one output register. Coefficients
// must be written via the csr port only while no beat is in flight; not enforced.
// Depends on pim_pkg, pim_front, pim_div_cell and pim_back.
module perspective_inverse_map_top
   import pim_pkg::*;
#(
   parameter int SRC_WIDTH  = 1920,
   parameter int SRC_HEIGHT = 1080,
   parameter int COORD_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [COEF_W-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

`include "perspective_inverse_map_top_assert.svh"

   coef_array_type coef_ff;
   logic    cv   [QBITS+1];
   logic    crdy [QBITS+1];
   div_type cd   [QBITS+1];

   // Coefficient registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   pim_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock), .reset(reset), .coef(coef_ff),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(cv[0]), .out_ready(crdy[0]), .out_data(cd[0])
   );

   // Division chain, most significant quotient bit first.
   for (genvar k = 0; k < QBITS; k++) begin : g_cell
      pim_div_cell #(.SHIFT(QBITS-1-k)) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(cv[k]), .in_ready(crdy[k]), .in_data(cd[k]),
         .out_valid(cv[k+1]), .out_ready(crdy[k+1]), .out_data(cd[k+1])
      );
   end

   pim_back #(.SRC_WIDTH(SRC_WIDTH), .SRC_HEIGHT(SRC_HEIGHT)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(cv[QBITS]), .in_ready(crdy[QBITS]), .in_data(cd[QBITS]),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(rsp_data)
   );

   `PIM_ASSERT_IMP(a_zero_when_out, clock, reset, rsp_valid && !rsp_data.inside_res, rsp_data.src_x == '0 && rsp_data.src_y == '0)
   `PIM_ASSERT_IMP(a_in_bounds, clock, reset, rsp_valid && rsp_data.inside_res, 32'(rsp_data.src_x) < SRC_WIDTH && 32'(rsp_data.src_y) < SRC_HEIGHT)
   `PIM_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid && coef_ff == COEF_RESET)

endmodule
